/* src/pnm_stream_decoder_unit_macros.svh */
// Assertion macros for the checker of the PNM stream decoder.
`ifndef PNM_STREAM_DECODER_UNIT_MACROS_SVH
`define PNM_STREAM_DECODER_UNIT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define PNM_ASSERT_CLK(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pnm stream decoder check failed");

// Assertion on the block clock clk_i and reset rst_ni.
`define PNM_ASSERT(label, prop) `PNM_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

/* src/pnm_pkg.sv */
// Types and constants shared by the PNM stream decoder modules.
package pnm_pkg;

  typedef enum logic [3:0] {
    PH_MAGIC0,
    PH_MAGIC1,
    PH_WIDTH,
    PH_HEIGHT,
    PH_MAXVAL,
    PH_DATA,
    PH_DONE,
    PH_FAULT
  } phase_e;

  typedef enum logic [1:0] {
    FMT_NONE,
    FMT_P4,
    FMT_P5,
    FMT_P6
  } format_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_MAGIC,
    ERR_MAXVAL,
    ERR_DEPTH
  } err_e;

  typedef enum logic [1:0] {
    BPS_1,
    BPS_2,
    BPS_4,
    BPS_8
  } bps_e;

  typedef enum logic {
    CMD_DATA,
    CMD_FAULT
  } cmd_kind_e;

  // One queue entry from the header parser to the unpacker.
  typedef struct packed {
    cmd_kind_e  kind;
    err_e       err;
    logic       start;
    bps_e       bps;
    logic [7:0] data;
  } cmd_t;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_4    = 8'h34;
  localparam logic [7:0] CH_5    = 8'h35;
  localparam logic [7:0] CH_6    = 8'h36;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_CR   = 8'h0d;

  localparam logic [7:0] MAXV_1   = 8'd1;
  localparam logic [7:0] MAXV_3   = 8'd3;
  localparam logic [7:0] MAXV_15  = 8'd15;
  localparam logic [7:0] MAXV_255 = 8'd255;

endpackage

/* src/pnm_parser.sv */
// Header parser: takes file bytes, tracks the header and queues data bytes or faults.
module pnm_parser import pnm_pkg::*; #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  input  logic [7:0]          byte_i,
  input  logic                sof_i,
  output logic                push_o,
  output cmd_t                cmd_o,
  output logic [DIM_BITS+1:0] row_len_o,
  output logic [DIM_BITS-1:0] height_o
);

  localparam int unsigned AW = DIM_BITS + 4;

  phase_e              phase_q, phase_d, phase_c;
  format_e             fmt_q, fmt_d;
  logic                cmt_q, cmt_d, cmt_c;
  logic [DIM_BITS-1:0] acc_q, acc_d, acc_c;
  logic                seen_q, seen_d, seen_c;
  logic [DIM_BITS-1:0] width_q, width_d;
  logic [DIM_BITS-1:0] height_q, height_d;
  bps_e                bps_q, bps_d;
  logic                pend_q, pend_d;

  logic                is_digit, is_eol, is_hash;
  logic [AW-1:0]       acc_sum;
  logic [DIM_BITS-1:0] acc_sat;
  logic                mv_ok;
  bps_e                mv_bps;
  logic                mv_depth_bad;

  // A start-of-file flag clears the parse state before this byte is looked at.
  assign phase_c = sof_i ? PH_MAGIC0 : phase_q;
  assign cmt_c   = sof_i ? 1'b0 : cmt_q;
  assign acc_c   = sof_i ? '0 : acc_q;
  assign seen_c  = sof_i ? 1'b0 : seen_q;

  assign is_digit = (byte_i >= CH_0) && (byte_i <= CH_9);
  assign is_eol   = (byte_i == CH_LF) || (byte_i == CH_CR);
  assign is_hash  = (byte_i == CH_HASH);

  // Decimal accumulate as acc*8 + acc*2 + digit, saturating at the all-ones value.
  assign acc_sum = {1'b0, acc_c, 3'b000} + {3'b000, acc_c, 1'b0} + AW'(byte_i[3:0]);
  assign acc_sat = (acc_sum > {4'b0000, {DIM_BITS{1'b1}}}) ? {DIM_BITS{1'b1}}
                                                           : acc_sum[DIM_BITS-1:0];

  always_comb begin
    mv_ok  = 1'b1;
    mv_bps = BPS_8;
    if (acc_c == DIM_BITS'(MAXV_1)) begin
      mv_bps = BPS_1;
    end else if (acc_c == DIM_BITS'(MAXV_3)) begin
      mv_bps = BPS_2;
    end else if (acc_c == DIM_BITS'(MAXV_15)) begin
      mv_bps = BPS_4;
    end else if (acc_c == DIM_BITS'(MAXV_255)) begin
      mv_bps = BPS_8;
    end else begin
      mv_ok = 1'b0;
    end
  end

  assign mv_depth_bad = (fmt_q == FMT_P6) && (mv_bps != BPS_8);

  // Next state.
  always_comb begin
    phase_d  = phase_q;
    fmt_d    = fmt_q;
    cmt_d    = cmt_q;
    acc_d    = acc_q;
    seen_d   = seen_q;
    width_d  = width_q;
    height_d = height_q;
    bps_d    = bps_q;
    pend_d   = pend_q;
    if (byte_valid_i) begin
      phase_d = phase_c;
      cmt_d   = cmt_c;
      acc_d   = acc_c;
      seen_d  = seen_c;
      case (phase_c)
        PH_MAGIC0: begin
          phase_d = (byte_i == CH_P) ? PH_MAGIC1 : PH_FAULT;
        end
        PH_MAGIC1: begin
          phase_d = PH_WIDTH;
          if (byte_i == CH_4) begin
            fmt_d = FMT_P4;
          end else if (byte_i == CH_5) begin
            fmt_d = FMT_P5;
          end else if (byte_i == CH_6) begin
            fmt_d = FMT_P6;
          end else begin
            phase_d = PH_FAULT;
          end
        end
        PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
          if (cmt_c) begin
            if (is_eol) begin
              cmt_d = 1'b0;
            end
          end else if (is_digit) begin
            acc_d  = acc_sat;
            seen_d = 1'b1;
          end else if (seen_c) begin
            acc_d  = '0;
            seen_d = 1'b0;
            cmt_d  = is_hash;
            case (phase_c)
              PH_WIDTH: begin
                width_d = acc_c;
                phase_d = PH_HEIGHT;
              end
              PH_HEIGHT: begin
                height_d = acc_c;
                if (fmt_q == FMT_P4) begin
                  bps_d   = BPS_1;
                  pend_d  = 1'b1;
                  phase_d = ((width_q == '0) || (acc_c == '0)) ? PH_DONE : PH_DATA;
                end else begin
                  phase_d = PH_MAXVAL;
                end
              end
              default: begin
                if (!mv_ok || mv_depth_bad) begin
                  phase_d = PH_FAULT;
                end else begin
                  bps_d   = mv_bps;
                  pend_d  = 1'b1;
                  phase_d = ((width_q == '0) || (height_q == '0)) ? PH_DONE : PH_DATA;
                end
              end
            endcase
          end else if (is_hash) begin
            cmt_d = 1'b1;
          end
        end
        PH_DATA: begin
          if (cmt_c) begin
            if (is_eol) begin
              cmt_d = 1'b0;
            end
          end else begin
            pend_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Queue entries.
  always_comb begin
    push_o      = 1'b0;
    cmd_o.kind  = CMD_DATA;
    cmd_o.err   = ERR_NONE;
    cmd_o.start = pend_q;
    cmd_o.bps   = bps_q;
    cmd_o.data  = byte_i;
    if (byte_valid_i) begin
      case (phase_c)
        PH_MAGIC0: begin
          if (byte_i != CH_P) begin
            push_o     = 1'b1;
            cmd_o.kind = CMD_FAULT;
            cmd_o.err  = ERR_MAGIC;
          end
        end
        PH_MAGIC1: begin
          if ((byte_i != CH_4) && (byte_i != CH_5) && (byte_i != CH_6)) begin
            push_o     = 1'b1;
            cmd_o.kind = CMD_FAULT;
            cmd_o.err  = ERR_MAGIC;
          end
        end
        PH_MAXVAL: begin
          if (!cmt_c && !is_digit && seen_c) begin
            if (!mv_ok) begin
              push_o     = 1'b1;
              cmd_o.kind = CMD_FAULT;
              cmd_o.err  = ERR_MAXVAL;
            end else if (mv_depth_bad) begin
              push_o     = 1'b1;
              cmd_o.kind = CMD_FAULT;
              cmd_o.err  = ERR_DEPTH;
            end
          end
        end
        PH_DATA: begin
          push_o = !cmt_c;
        end
        default: ;
      endcase
    end
  end

  // Samples per row: width for gray and bitmap images, three times width for color.
  assign row_len_o = (fmt_q == FMT_P6) ? ({2'b00, width_q} + {1'b0, width_q, 1'b0})
                                       : {2'b00, width_q};
  assign height_o  = height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MAGIC0;
      fmt_q    <= FMT_NONE;
      cmt_q    <= 1'b0;
      acc_q    <= '0;
      seen_q   <= 1'b0;
      width_q  <= '0;
      height_q <= '0;
      bps_q    <= BPS_1;
      pend_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      fmt_q    <= fmt_d;
      cmt_q    <= cmt_d;
      acc_q    <= acc_d;
      seen_q   <= seen_d;
      width_q  <= width_d;
      height_q <= height_d;
      bps_q    <= bps_d;
      pend_q   <= pend_d;
    end
  end

endmodule

/* src/pnm_fifo.sv */
// Small first-in first-out queue between the parser and the unpacker.
module pnm_fifo import pnm_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned AW = $clog2(FIFO_DEPTH);

  logic [WIDTH-1:0] mem [FIFO_DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [AW:0]      count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (AW+1)'(FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (AW+1)'(1);
      end
    end
  end

endmodule

/* src/pnm_unpack.sv */
// Unpacker: bytes to widened samples, one per cycle unless stalled, with row and image ends.
module pnm_unpack import pnm_pkg::*; #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  cmd_t                cmd_i,
  input  logic [DIM_BITS+1:0] row_len_i,
  input  logic [DIM_BITS-1:0] height_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          pixel_o,
  output logic                last_o,
  output logic                row_end_o,
  output logic                image_end_o,
  output err_e                err_o
);

  logic                busy_q, busy_d;
  cmd_kind_e           kind_q, kind_d;
  err_e                err_q, err_d;
  bps_e                bps_q, bps_d;
  logic [7:0]          shreg_q, shreg_d;
  logic [2:0]          k_q, k_d;
  logic [DIM_BITS+1:0] row_len_q, row_len_d;
  logic [DIM_BITS-1:0] height_q, height_d;
  logic [DIM_BITS+1:0] col_q, col_d;
  logic [DIM_BITS-1:0] row_q, row_d;
  logic                done_q, done_d;

  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_pix_q;
  logic                out_last_q, out_rend_q, out_iend_q;
  err_e                out_err_q;

  logic                take, emit, finishing, is_fault;
  logic [7:0]          sample;
  logic [7:0]          shifted;
  logic [2:0]          k_max;
  logic [DIM_BITS+1:0] col_inc;
  logic [DIM_BITS-1:0] row_inc;
  logic                rend, iend, seg_last;

  assign take     = !out_valid_q || out_ready_i;
  assign emit     = busy_q && take;
  assign is_fault = (kind_q == CMD_FAULT);

  // The current sample sits in the top bits of the shift register.
  always_comb begin
    case (bps_q)
      BPS_1: begin
        sample  = {8{shreg_q[7]}};
        shifted = {shreg_q[6:0], 1'b0};
        k_max   = 3'd7;
      end
      BPS_2: begin
        sample  = {4{shreg_q[7:6]}};
        shifted = {shreg_q[5:0], 2'b00};
        k_max   = 3'd3;
      end
      BPS_4: begin
        sample  = {2{shreg_q[7:4]}};
        shifted = {shreg_q[3:0], 4'b0000};
        k_max   = 3'd1;
      end
      default: begin
        sample  = shreg_q;
        shifted = shreg_q;
        k_max   = 3'd0;
      end
    endcase
  end

  assign col_inc   = col_q + (DIM_BITS+2)'(1);
  assign row_inc   = row_q + DIM_BITS'(1);
  assign rend      = !is_fault && (col_inc >= row_len_q);
  assign iend      = rend && (row_inc >= height_q);
  // A row end cuts the byte short: its padding bits are dropped.
  assign seg_last  = is_fault || (k_q == k_max) || rend;
  assign finishing = emit && seg_last;
  assign cmd_pop_o = cmd_valid_i && (!busy_q || finishing);

  always_comb begin
    busy_d    = busy_q;
    kind_d    = kind_q;
    err_d     = err_q;
    bps_d     = bps_q;
    shreg_d   = shreg_q;
    k_d       = k_q;
    row_len_d = row_len_q;
    height_d  = height_q;
    col_d     = col_q;
    row_d     = row_q;
    done_d    = done_q;
    if (emit && !is_fault) begin
      shreg_d = shifted;
      k_d     = k_q + 3'd1;
      col_d   = rend ? '0 : col_inc;
      if (rend) begin
        row_d = row_inc;
      end
      if (iend) begin
        done_d = 1'b1;
      end
    end
    if (finishing) begin
      busy_d = 1'b0;
    end
    if (cmd_pop_o) begin
      kind_d  = cmd_i.kind;
      err_d   = cmd_i.err;
      bps_d   = cmd_i.bps;
      shreg_d = cmd_i.data;
      k_d     = 3'd0;
      if (cmd_i.kind == CMD_FAULT) begin
        busy_d = 1'b1;
      end else if (cmd_i.start) begin
        row_len_d = row_len_i;
        height_d  = height_i;
        col_d     = '0;
        row_d     = '0;
        done_d    = 1'b0;
        busy_d    = 1'b1;
      end else begin
        // Bytes after the end of the image are dropped here.
        busy_d = !done_d;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      kind_q      <= CMD_DATA;
      err_q       <= ERR_NONE;
      bps_q       <= BPS_8;
      k_q         <= '0;
      row_len_q   <= '0;
      height_q    <= '0;
      col_q       <= '0;
      row_q       <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      kind_q      <= kind_d;
      err_q       <= err_d;
      bps_q       <= bps_d;
      k_q         <= k_d;
      row_len_q   <= row_len_d;
      height_q    <= height_d;
      col_q       <= col_d;
      row_q       <= row_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    if (emit) begin
      out_pix_q  <= is_fault ? 8'h00 : sample;
      out_last_q <= seg_last;
      out_rend_q <= rend;
      out_iend_q <= iend;
      out_err_q  <= is_fault ? err_q : ERR_NONE;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_o     = out_pix_q;
  assign last_o      = out_last_q;
  assign row_end_o   = out_rend_q;
  assign image_end_o = out_iend_q;
  assign err_o       = out_err_q;

endmodule

/* src/pnm_stream_decoder_unit.sv */
// Usage: binary PNM (P4, P5, P6) decoder that streams file bytes in and samples out.
// The input channel takes one file byte per word on s_axis_tdata; s_axis_tuser marks the
// first byte of a new file and resets the parse phase, comment and number state first.
// The output channel gives one widened 8-bit sample per word on m_axis_tdata, with
// m_axis_tlast on the last word caused by an input byte and m_axis_tuser holding the
// row end, image end and error code. An error word carries a zero sample and ends the
// file; later bytes give nothing until the next start-of-file mark.
// Header bytes are taken one per cycle while s_axis_tready is high; only a bad one gives
// a word, the error word. Each data byte gives 8, 4, 2 or 1 samples at one word per cycle
// while the receiver takes them (fewer at a row end); the next byte is loaded as the last
// sample of the current one is emitted. Output words are registered.
// A four-entry queue sits between the header parser and the unpacker, so bytes keep
// flowing while words wait; when the receiver stalls, the output word holds, the queue
// fills and s_axis_tready drops. Reset clears the parser, the queue and the output.
module pnm_stream_decoder_unit import pnm_pkg::*; #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] start_of_file
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] pixel
  output logic       m_axis_tlast,
  output logic [3:0] m_axis_tuser    // [0] row_end, [1] image_end, [3:2] error_code
);

  localparam int unsigned QW = $bits(cmd_t) + 2 * DIM_BITS + 2;

  logic                accept;
  logic                push;
  cmd_t                push_cmd;
  logic [DIM_BITS+1:0] push_row_len;
  logic [DIM_BITS-1:0] push_height;
  logic                fifo_full;
  logic                fifo_valid;
  logic                fifo_pop;
  logic [QW-1:0]       fifo_rdata;
  cmd_t                pop_cmd;
  logic [DIM_BITS+1:0] pop_row_len;
  logic [DIM_BITS-1:0] pop_height;
  logic                row_end, image_end;
  err_e                err;

  assign s_axis_tready = !fifo_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  pnm_parser #(
    .DIM_BITS (DIM_BITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (accept),
    .byte_i       (s_axis_tdata),
    .sof_i        (s_axis_tuser),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .row_len_o    (push_row_len),
    .height_o     (push_height)
  );

  pnm_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({push_row_len, push_height, push_cmd}),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .valid_o (fifo_valid),
    .rdata_o (fifo_rdata)
  );

  assign {pop_row_len, pop_height, pop_cmd} = fifo_rdata;

  pnm_unpack #(
    .DIM_BITS (DIM_BITS)
  ) u_unpack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (fifo_valid),
    .cmd_i       (pop_cmd),
    .row_len_i   (pop_row_len),
    .height_i    (pop_height),
    .cmd_pop_o   (fifo_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .pixel_o     (m_axis_tdata),
    .last_o      (m_axis_tlast),
    .row_end_o   (row_end),
    .image_end_o (image_end),
    .err_o       (err)
  );

  assign m_axis_tuser = {err, image_end, row_end};

endmodule

/* src/pnm_checker.sv */
// Port-level checks for the PNM stream decoder, bound to its top level.
`include "pnm_stream_decoder_unit_macros.svh"

module pnm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [3:0] m_axis_tuser
);

  // A stalled output word keeps its contents.
  `PNM_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // An error word is alone for its byte, carries a zero sample and no end flags.
  `PNM_ASSERT(a_err_word, m_axis_tvalid && (m_axis_tuser[3:2] != 2'b00) |-> m_axis_tlast && (m_axis_tdata == 8'h00) && (m_axis_tuser[1:0] == 2'b00))

  // The end of an image is also the end of a row.
  `PNM_ASSERT(a_image_row, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])

  // A row end finishes the byte, because the remaining bits are padding.
  `PNM_ASSERT(a_row_last, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)

endmodule

bind pnm_stream_decoder_unit pnm_checker u_pnm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

/* tb/pnm_stream_decoder_unit_test.sv */
// Self-checking testbench for the PNM stream decoder: it sends file bytes and checks each sample word.
`timescale 1ns / 1ps

module pnm_stream_decoder_unit_test;
  import pnm_pkg::*;

  localparam int unsigned DIM_BITS = 16;
  localparam int unsigned DIM_MAX = (1 << DIM_BITS) - 1;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic [7:0] pixel;
    logic       last;
    logic       rend;
    logic       iend;
    err_e       err;
  } pnm_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tuser = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic [3:0] m_axis_tuser;

  pnm_stream_decoder_unit #(.DIM_BITS(DIM_BITS)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  pnm_word_t   predicted_words[$];
  logic [7:0]  file_q[$];
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycles = 0;
  int unsigned hold = 0;
  bit          steady = 1'b0;

  // Decoder state as the predictor tracks it.
  phase_e              phase;
  format_e             fmt;
  logic                in_comment;
  logic [DIM_BITS-1:0] accum;
  logic                have_digit;
  logic [DIM_BITS-1:0] img_w;
  logic [DIM_BITS-1:0] img_h;
  logic [3:0]          sample_bits;
  logic [1:0]          chans;
  logic [DIM_BITS+1:0] col;
  logic [DIM_BITS-1:0] row;

  function automatic void clear_parser();
    phase = PH_MAGIC0;
    fmt = FMT_NONE;
    in_comment = 1'b0;
    accum = '0;
    have_digit = 1'b0;
    img_w = '0;
    img_h = '0;
    sample_bits = '0;
    chans = '0;
    col = '0;
    row = '0;
  endfunction

  function automatic void post_fault(err_e code);
    pnm_word_t w;
    phase = PH_FAULT;
    w = '{pixel: 8'h00, last: 1'b1, rend: 1'b0, iend: 1'b0, err: code};
    predicted_words.push_back(w);
  endfunction

  function automatic void enter_pixels();
    col = '0;
    row = '0;
    phase = (img_w == 0 || img_h == 0) ? PH_DONE : PH_DATA;
  endfunction

  function automatic void close_number(logic [7:0] b);
    logic [DIM_BITS-1:0] v;
    logic [3:0]          nb;
    v = accum;
    accum = '0;
    have_digit = 1'b0;
    if (b == CH_HASH) in_comment = 1'b1;
    case (phase)
      PH_WIDTH: begin
        img_w = v;
        phase = PH_HEIGHT;
      end
      PH_HEIGHT: begin
        img_h = v;
        if (fmt == FMT_P4) begin
          sample_bits = 4'd1;
          enter_pixels();
        end else begin
          phase = PH_MAXVAL;
        end
      end
      default: begin
        nb = 4'd0;
        if (v == MAXV_1) nb = 4'd1;
        else if (v == MAXV_3) nb = 4'd2;
        else if (v == MAXV_15) nb = 4'd4;
        else if (v == MAXV_255) nb = 4'd8;
        if (nb == 0) begin
          post_fault(ERR_MAXVAL);
        end else if (fmt == FMT_P6 && nb < 8) begin
          post_fault(ERR_DEPTH);
        end else begin
          sample_bits = nb;
          enter_pixels();
        end
      end
    endcase
  endfunction

  // Samples come out MSB first; a row end cuts the rest of the byte off as padding.
  function automatic void unpack_pixels(logic [7:0] b);
    logic [DIM_BITS+1:0] row_len;
    logic [7:0]          field;
    logic [7:0]          pix;
    int unsigned         mask;
    int                  n;
    int                  sh;
    pnm_word_t           w;
    row_len = img_w * chans;
    n = 8 / sample_bits;
    mask = (1 << sample_bits) - 1;
    for (int k = 0; k < n; k++) begin
      sh = 8 - sample_bits * (k + 1);
      field = 8'((b >> sh) & mask);
      case (sample_bits)
        4'd1: pix = (field != 0) ? 8'hff : 8'h00;
        4'd2: pix = field * 8'h55;
        4'd4: pix = field * 8'h11;
        default: pix = field;
      endcase
      w = '{pixel: pix, last: 1'b0, rend: 1'b0, iend: 1'b0, err: ERR_NONE};
      col = col + 1;
      if (col >= row_len) begin
        w.rend = 1'b1;
        col = '0;
        row = row + 1;
        if (row >= img_h) begin
          w.iend = 1'b1;
          phase = PH_DONE;
        end
      end
      w.last = (k == n - 1) || w.rend;
      predicted_words.push_back(w);
      if (w.rend) break;
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic sof);
    int unsigned acc;
    if (sof) clear_parser();
    case (phase)
      PH_MAGIC0: begin
        if (b != CH_P) post_fault(ERR_MAGIC);
        else phase = PH_MAGIC1;
      end
      PH_MAGIC1: begin
        if (b == CH_4) begin
          fmt = FMT_P4;
          chans = 2'd1;
          phase = PH_WIDTH;
        end else if (b == CH_5) begin
          fmt = FMT_P5;
          chans = 2'd1;
          phase = PH_WIDTH;
        end else if (b == CH_6) begin
          fmt = FMT_P6;
          chans = 2'd3;
          phase = PH_WIDTH;
        end else begin
          post_fault(ERR_MAGIC);
        end
      end
      PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
        if (in_comment) begin
          if (b == CH_LF || b == CH_CR) in_comment = 1'b0;
        end else if (b >= CH_0 && b <= CH_9) begin
          acc = accum * 10 + (b - CH_0);
          accum = DIM_BITS'((acc > DIM_MAX) ? DIM_MAX : acc);
          have_digit = 1'b1;
        end else if (have_digit) begin
          close_number(b);
        end else if (b == CH_HASH) begin
          in_comment = 1'b1;
        end
      end
      PH_DATA: begin
        if (in_comment) begin
          if (b == CH_LF || b == CH_CR) in_comment = 1'b0;
        end else begin
          unpack_pixels(b);
        end
      end
      default: ;
    endcase
  endfunction

  // Mostly short gaps, a few long ones; none at all while steady is set.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void put_text(string s);
    foreach (s[i]) file_q.push_back(s[i]);
  endfunction

  function automatic void put_num(int unsigned v);
    if ($urandom_range(0, 9) == 0) file_q.push_back(CH_0);
    put_text($sformatf("%0d", v));
  endfunction

  // One delimiter: a blank, a control byte, any other non-digit, or a whole comment.
  function automatic void put_sep();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1: begin
        file_q.push_back(CH_HASH);
        repeat ($urandom_range(0, 4)) begin
          c = 8'($urandom_range(0, 255));
          file_q.push_back((c == CH_LF || c == CH_CR) ? 8'h41 : c);
        end
        file_q.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
      end
      2: file_q.push_back(CH_LF);
      3: file_q.push_back(CH_CR);
      4: file_q.push_back(8'h09);
      5: begin
        c = 8'($urandom_range(0, 255));
        file_q.push_back((c == CH_HASH || (c >= CH_0 && c <= CH_9)) ? 8'h20 : c);
      end
      default: file_q.push_back(8'h20);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic sof);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= sof;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_byte(b, sof);
    bytes_sent++;
  endtask

  task automatic send_file(input bit with_sof);
    foreach (file_q[i]) send_byte(file_q[i], with_sof && i == 0);
    file_q.delete();
  endtask

  // P4 rows of 10 pixels: the second byte of each row carries six padding bits.
  task automatic test_bitmap_padding();
    put_text("P4 10 2");
    file_q.push_back(CH_LF);
    file_q.push_back(8'hA5);
    file_q.push_back(8'hFF);
    file_q.push_back(8'h00);
    file_q.push_back(8'h7F);
    file_q.push_back(8'hFF);
    send_file(1'b1);
  endtask

  task automatic test_gray_depths();
    put_text("P5 3 1 3 ");
    file_q.push_back(8'hE4);
    send_file(1'b1);
    // A '#' right after maxval ends the header; data follows the comment.
    put_text("P5 2 1 15#x");
    file_q.push_back(CH_CR);
    file_q.push_back(8'h9F);
    send_file(1'b1);
    put_text("P5#a");
    file_q.push_back(CH_LF);
    put_text("9 1 1 ");
    file_q.push_back(8'hB6);
    file_q.push_back(8'h80);
    send_file(1'b1);
    put_text("P5 1 1 255 ");
    file_q.push_back(8'hFF);
    send_file(1'b1);
  endtask

  task automatic test_color_depth();
    put_text("P6 1 1 255 ");
    file_q.push_back(8'h00);
    file_q.push_back(8'h80);
    file_q.push_back(8'hFF);
    send_file(1'b1);
    put_text("P6 1 1 15 ");
    file_q.push_back(8'h12);
    send_file(1'b1);
  endtask

  task automatic test_header_faults();
    put_text("Q5");
    send_file(1'b1);
    put_text("P7 ");
    send_file(1'b1);
    put_text("P5 1 1 7 ");
    file_q.push_back(8'h33);
    send_file(1'b1);
    put_text("P5 1 1 99999 ");
    send_file(1'b1);
    // Zero width: no samples at all.
    put_text("P4 0 3 ");
    file_q.push_back(8'hFF);
    send_file(1'b1);
  endtask

  task automatic test_restart_and_saturation();
    put_text("P5 070000 1 255 ");
    file_q.push_back(8'h5A);
    file_q.push_back(8'hC3);
    send_file(1'b1);
    put_text("P5 2 2 255 ");
    file_q.push_back(8'h01);
    send_file(1'b1);
    put_text("P4 3 1 ");
    file_q.push_back(8'hA0);
    send_file(1'b1);
  endtask

  task automatic test_random_files();
    int unsigned stop_at;
    int unsigned r;
    int unsigned w;
    int unsigned h;
    int unsigned maxv;
    int unsigned nb;
    int unsigned ch;
    int unsigned total;
    format_e     f;
    stop_at = bytes_sent + 100;
    while (bytes_sent < stop_at) begin
      steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 78) begin
        f = format_e'($urandom_range(1, 3));
        file_q.push_back(CH_P);
        file_q.push_back(f == FMT_P4 ? CH_4 : (f == FMT_P5 ? CH_5 : CH_6));
        case ($urandom_range(0, 3))
          0: maxv = 1;
          1: maxv = 3;
          2: maxv = 15;
          default: maxv = 255;
        endcase
        if (f == FMT_P6 && $urandom_range(0, 7) != 0) maxv = 255;
        if ($urandom_range(0, 19) == 0)
          maxv = $urandom_range(0, 1) ? $urandom_range(0, 400) : 99999;
        if (f == FMT_P4 || maxv == 1) nb = 1;
        else if (maxv == 3) nb = 2;
        else if (maxv == 15) nb = 4;
        else nb = 8;
        ch = (f == FMT_P6) ? 3 : 1;
        r = $urandom_range(0, 19);
        w = (r == 0) ? 0 : (r < 17 ? $urandom_range(1, 6) : $urandom_range(7, 24));
        h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3);
        total = (w * ch * nb + 7) / 8;
        if (total * h > 40) h = 1;
        total = total * h;
        put_sep();
        if ($urandom_range(0, 3) == 0) put_sep();
        put_num(w);
        put_sep();
        if ($urandom_range(0, 3) == 0) put_sep();
        put_num(h);
        if (f != FMT_P4) begin
          put_sep();
          if ($urandom_range(0, 3) == 0) put_sep();
          put_num(maxv);
        end
        // Exactly one delimiter after the last number, or data would start early.
        put_sep();
        if ($urandom_range(0, 9) == 0) total = $urandom_range(0, total);
        if ($urandom_range(0, 9) == 0) total += $urandom_range(1, 3);
        repeat (total) file_q.push_back(8'($urandom_range(0, 255)));
        send_file(1'b1);
      end else if (r < 90) begin
        repeat ($urandom_range(1, 5)) file_q.push_back(8'($urandom_range(0, 255)));
        send_file(1'($urandom_range(0, 1)));
      end else begin
        if ($urandom_range(0, 1)) begin
          file_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          file_q.push_back(CH_P);
          file_q.push_back(8'($urandom_range(0, 255)));
        end
        repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom_range(0, 255)));
        send_file(1'b1);
      end
    end
    steady = 1'b0;
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (hold > 0) begin
      m_axis_tready <= 1'b0;
      hold--;
    end else begin
      m_axis_tready <= 1'b1;
      hold = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    pnm_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (predicted_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got pixel %0h tlast %b tuser %b",
                 $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
        mismatches++;
      end else begin
        want = predicted_words.pop_front();
        check_field("pixel", want.pixel, m_axis_tdata);
        check_field("run_last", 8'(want.last), 8'(m_axis_tlast));
        check_field("row_end", 8'(want.rend), 8'(m_axis_tuser[0]));
        check_field("image_end", 8'(want.iend), 8'(m_axis_tuser[1]));
        check_field("error_code", 8'(want.err), 8'(m_axis_tuser[3:2]));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    clear_parser();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_bitmap_padding();
    test_gray_depths();
    test_color_depth();
    test_header_faults();
    test_restart_and_saturation();
    test_random_files();
    s_axis_tvalid <= 1'b0;
    while (predicted_words.size() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* pnm_stream_decoder_unit.f */
+incdir+src
src/pnm_pkg.sv
src/pnm_parser.sv
src/pnm_fifo.sv
src/pnm_unpack.sv
src/pnm_stream_decoder_unit.sv
src/pnm_checker.sv
tb/pnm_stream_decoder_unit_test.sv
